### rtl/tpbb_pkg.sv
// Package with shared constants and types for the three-pass box blur.
`timescale 1ns / 1ps
package tpbb_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxRadius = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned AddrW = 16;
  localparam int unsigned PixW  = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
  localparam logic [CmdW-1:0] CMD_RUN   = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [AddrW-1:0] pixel_address;
    logic [PixW-1:0]  pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] read_value;
    logic            run_done;
  } out_item_t;
endpackage

### rtl/tpbb_if.sv
// Valid/ready channel interface carrying one payload per transfer.
`timescale 1ns / 1ps
interface tpbb_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tpbb_div.sv
// Sequential restoring divider for one channel sum by the box size.
`timescale 1ns / 1ps
module tpbb_div #(
  parameter int unsigned SumW = 17,
  parameter int unsigned DivW = 9
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SumW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output logic            done,
  output logic [7:0]      quotient
);
  localparam int unsigned CntW = $clog2(SumW + 1);
  logic [SumW-1:0] quo_r, quo_nxt;
  logic [SumW:0]   rem_r, rem_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [SumW:0]   shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[SumW-1:0], quo_r[SumW-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(SumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SumW-2:0], 1'b0};
      if (shifted >= (SumW+1)'(divisor)) begin
        rem_nxt    = shifted - (SumW+1)'(divisor);
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[7:0];
endmodule

### rtl/three_pass_box_blur.sv
// Top level of the three-pass box blur with image and scratch memories.
// Pixel writes and reads take one memory access each; a read result passes
// through the memory output register and then the result register. A new item
// is taken only in the idle state, with no read result pending and the result
// register empty or being emptied. A run blurs three times, and each pass
// walks every pixel once horizontally into the scratch memory and once
// vertically back into the image memory. For each pixel it reads 2*radius+1
// neighbors one per cycle through the single read port of the source memory.
// It then divides the four channel sums in turn in a shared restoring divider.
// A radius of zero finishes a run without blurring. The memories need no
// clearing after reset.
`timescale 1ns / 1ps
module three_pass_box_blur #(
  parameter int unsigned MAX_WIDTH  = tpbb_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = tpbb_pkg::MaxHeight,
  parameter int unsigned MAX_RADIUS = tpbb_pkg::MaxRadius
) (
  input  logic clk,
  input  logic rst_n,
  tpbb_if.sink   in_ch,
  tpbb_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [tpbb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tpbb_pkg::CfgDataW-1:0] cfg_data
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned MemAw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = (XW > YW) ? XW : YW;
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned KW    = RW + 2;
  localparam int unsigned SumW  = 8 + KW;
  localparam int unsigned DivW  = RW + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [tpbb_pkg::PixW-1:0] img_mem [Depth];
  logic [tpbb_pkg::PixW-1:0] scr_mem [Depth];

  logic [8:0]    width_r, height_r;
  logic [5:0]    radius_r;
  logic [2:0]    st_r;
  logic [1:0]    pass_r;
  logic          vert_r;
  logic [CW-1:0] x_r, y_r, w_r, h_r;
  logic [RW-1:0] r_r;
  logic [KW-1:0] k_r;
  logic          rd_v_r;
  logic          acc_last_r;
  logic [SumW-1:0] sum_r [4];
  logic [1:0]    ch_r;
  logic [tpbb_pkg::PixW-1:0] res_px_r;
  logic          div_start;
  logic          div_done;
  logic [7:0]    div_q;
  logic [MemAw-1:0] rd_addr, wr_addr;
  logic [tpbb_pkg::PixW-1:0] img_q_r, scr_q_r;
  logic          out_v_r, rd_pend_r, out_done_r, out_from_mem_r;
  logic [tpbb_pkg::PixW-1:0] out_val_r;

  logic [8:0]    w_sat, h_sat;
  logic [5:0]    r_sat;
  logic          in_fire, out_free;
  logic [tpbb_pkg::CmdW-1:0]  in_cmd;
  logic [tpbb_pkg::AddrW-1:0] in_addr;
  logic          addr_ok;
  logic signed [CW+KW:0] pos;
  logic [CW-1:0] pos_cl, cur_pos, cur_lim;
  logic [2*CW-1:0] lin_rd, lin_wr;
  logic          mem_wr_img, mem_wr_scr;

  assign in_cmd  = in_ch.data.cmd;
  assign in_addr = in_ch.data.pixel_address;
  assign addr_ok = 32'(in_addr) < 32'(Depth);

  always_comb begin
    w_sat = (width_r == 9'd0) ? 9'd1 :
            ((32'(width_r) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r);
    h_sat = (height_r == 9'd0) ? 9'd1 :
            ((32'(height_r) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_r);
    r_sat = (32'(radius_r) > 32'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : radius_r;
  end

  // A new item is taken only with no read result pending and the output free.
  assign out_free = !out_v_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && !rd_pend_r && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign cur_pos = vert_r ? y_r : x_r;
  assign cur_lim = vert_r ? h_r : w_r;
  always_comb begin
    pos = $signed({1'b0, cur_pos}) + $signed({1'b0, k_r}) - $signed({1'b0, r_r});
    if (pos < 0) pos_cl = '0;
    else if (pos >= $signed({1'b0, cur_lim})) pos_cl = cur_lim - 1'b1;
    else pos_cl = pos[CW-1:0];
  end
  assign lin_rd = vert_r ? (pos_cl * w_r + (2*CW)'(x_r)) : (y_r * w_r + (2*CW)'(pos_cl));
  assign lin_wr = y_r * w_r + (2*CW)'(x_r);
  assign rd_addr = MemAw'(lin_rd);
  assign wr_addr = MemAw'(lin_wr);

  assign div_start = (st_r == ST_DIV);
  tpbb_div #(.SumW(SumW), .DivW(DivW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(sum_r[ch_r]), .divisor(DivW'({r_r, 1'b1})),
    .done(div_done), .quotient(div_q)
  );

  assign mem_wr_scr = (st_r == ST_WAIT) && div_done && (ch_r == 2'd3) && !vert_r;
  assign mem_wr_img = (st_r == ST_WAIT) && div_done && (ch_r == 2'd3) && vert_r;

  always_ff @(posedge clk) begin
    if (in_fire && in_cmd == tpbb_pkg::CMD_WRITE && addr_ok)
      img_mem[MemAw'(in_addr)] <= in_ch.data.pixel_value;
    else if (mem_wr_img)
      img_mem[wr_addr] <= {div_q, res_px_r[31:8]};
    if (in_fire) img_q_r <= img_mem[MemAw'(in_addr)];
    else img_q_r <= img_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_wr_scr) scr_mem[wr_addr] <= {div_q, res_px_r[31:8]};
    scr_q_r <= scr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      radius_r <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpbb_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        tpbb_pkg::CFG_HEIGHT: height_r <= cfg_data;
        tpbb_pkg::CFG_RADIUS: radius_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rd_pend_r <= 1'b0;
      out_v_r <= 1'b0;
      rd_v_r <= 1'b0;
      acc_last_r <= 1'b0;
    end else begin
      rd_pend_r <= 1'b0;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (rd_pend_r) begin
        out_v_r <= 1'b1;
      end
      if (in_fire && in_cmd == tpbb_pkg::CMD_READ) begin
        rd_pend_r <= 1'b1;
        out_from_mem_r <= addr_ok;
        out_done_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_fire && in_cmd == tpbb_pkg::CMD_RUN) begin
            w_r <= CW'(w_sat);
            h_r <= CW'(h_sat);
            r_r <= RW'(r_sat);
            x_r <= '0;
            y_r <= '0;
            k_r <= '0;
            pass_r <= 2'd0;
            vert_r <= 1'b0;
            rd_v_r <= 1'b0;
            acc_last_r <= 1'b0;
            for (int c = 0; c < 4; c++) sum_r[c] <= '0;
            st_r <= (r_sat == 6'd0) ? ST_DONE : ST_ACC;
          end
        end
        ST_ACC: begin
          rd_v_r <= !acc_last_r;
          if (rd_v_r) begin
            for (int c = 0; c < 4; c++)
              sum_r[c] <= sum_r[c] + SumW'(vert_r ? scr_q_r[8*c +: 8] : img_q_r[8*c +: 8]);
          end
          if (!acc_last_r) begin
            if (k_r == KW'({r_r, 1'b0})) acc_last_r <= 1'b1;
            else k_r <= k_r + 1'b1;
          end else if (rd_v_r) begin
            ch_r <= 2'd0;
            st_r <= ST_DIV;
          end
        end
        ST_DIV: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            res_px_r <= {div_q, res_px_r[31:8]};
            if (ch_r != 2'd3) begin
              ch_r <= ch_r + 1'b1;
              st_r <= ST_DIV;
            end else begin
              k_r <= '0;
              acc_last_r <= 1'b0;
              rd_v_r <= 1'b0;
              for (int c = 0; c < 4; c++) sum_r[c] <= '0;
              st_r <= ST_ACC;
              if (!vert_r) begin
                if (x_r != w_r - 1'b1) x_r <= x_r + 1'b1;
                else begin
                  x_r <= '0;
                  if (y_r != h_r - 1'b1) y_r <= y_r + 1'b1;
                  else begin
                    y_r <= '0;
                    vert_r <= 1'b1;
                  end
                end
              end else begin
                if (y_r != h_r - 1'b1) y_r <= y_r + 1'b1;
                else begin
                  y_r <= '0;
                  if (x_r != w_r - 1'b1) x_r <= x_r + 1'b1;
                  else begin
                    x_r <= '0;
                    vert_r <= 1'b0;
                    if (pass_r == 2'd2) st_r <= ST_DONE;
                    else pass_r <= pass_r + 1'b1;
                  end
                end
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_v_r) begin
            out_v_r <= 1'b1;
            out_done_r <= 1'b1;
            out_from_mem_r <= 1'b0;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
    if (rd_pend_r) out_val_r <= out_from_mem_r ? img_q_r : '0;
    if (st_r == ST_DONE) out_val_r <= '0;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data = {out_val_r, out_done_r};
endmodule

### rtl/tpbb_checker.sv
// Port-level checker for the three-pass box blur, bound to the top level.
`timescale 1ns / 1ps
module tpbb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic [tpbb_pkg::CmdW-1:0] in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic [tpbb_pkg::PixW-1:0] out_read_value,
  input logic out_run_done
);
  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done |-> out_read_value == '0)
    else $error("run result carries a nonzero value");
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result waits");
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == tpbb_pkg::CMD_WRITE && !out_valid |=> !out_valid)
    else $error("write produced a result");
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == tpbb_pkg::CMD_READ |=> ##1 out_valid && !out_run_done)
    else $error("read result missing");
endmodule

bind three_pass_box_blur tpbb_checker u_tpbb_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_read_value(out_ch.data.read_value), .out_run_done(out_ch.data.run_done)
);

### test/three_pass_box_blur_checker.sv
// Checker that predicts the blur block's results and compares each result transfer.
`timescale 1ns / 1ps
module three_pass_box_blur_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  tpbb_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  tpbb_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [tpbb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tpbb_pkg::CfgDataW-1:0] cfg_data,
  output int                            pending,
  output int                            fail_count
);
  localparam int unsigned StoreDepth = tpbb_pkg::MaxWidth * tpbb_pkg::MaxHeight;

  logic [tpbb_pkg::PixW-1:0] image_mem [0:StoreDepth-1];
  logic [tpbb_pkg::PixW-1:0] scratch_mem [0:StoreDepth-1];
  logic [8:0] width_reg;
  logic [8:0] height_reg;
  logic [5:0] radius_reg;
  tpbb_pkg::out_item_t awaited_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input logic [tpbb_pkg::PixW-1:0] got,
                        input logic [tpbb_pkg::PixW-1:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
    fail_count++;
  endtask

  function automatic logic [tpbb_pkg::PixW-1:0] box_average(
      const ref logic [tpbb_pkg::PixW-1:0] src [0:StoreDepth-1],
      input int base, input int stride, input int pos, input int len, input int r);
    int unsigned sums [4];
    int k, q, c;
    logic [tpbb_pkg::PixW-1:0] px, res;
    for (c = 0; c < 4; c++) sums[c] = 0;
    for (k = -r; k <= r; k++) begin
      q = pos + k;
      if (q < 0) q = 0;
      if (q > len - 1) q = len - 1;
      px = src[base + q * stride];
      for (c = 0; c < 4; c++) sums[c] += px[8*c +: 8];
    end
    res = '0;
    for (c = 0; c < 4; c++) res[8*c +: 8] = 8'(sums[c] / (2 * r + 1));
    return res;
  endfunction

  task automatic blur_image();
    int w, h, r, p, x, y;
    w = (width_reg == 0) ? 1 :
        (width_reg > tpbb_pkg::MaxWidth) ? tpbb_pkg::MaxWidth : int'(width_reg);
    h = (height_reg == 0) ? 1 :
        (height_reg > tpbb_pkg::MaxHeight) ? tpbb_pkg::MaxHeight : int'(height_reg);
    r = (radius_reg > tpbb_pkg::MaxRadius) ? tpbb_pkg::MaxRadius : int'(radius_reg);
    if (r < 1) return;
    for (p = 0; p < 3; p++) begin
      for (y = 0; y < h; y++)
        for (x = 0; x < w; x++)
          scratch_mem[y*w + x] = box_average(image_mem, y*w, 1, x, w, r);
      for (x = 0; x < w; x++)
        for (y = 0; y < h; y++)
          image_mem[y*w + x] = box_average(scratch_mem, x, w, y, h, r);
    end
  endtask

  always @(posedge clk) begin
    tpbb_pkg::out_item_t exp_item;
    if (!rst_n) begin
      width_reg <= 9'd256;
      height_reg <= 9'd256;
      radius_reg <= 6'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpbb_pkg::CFG_WIDTH: width_reg <= cfg_data;
          tpbb_pkg::CFG_HEIGHT: height_reg <= cfg_data;
          tpbb_pkg::CFG_RADIUS: radius_reg <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report("unexpected transfer", out_data.read_value, '0);
        end else begin
          exp_item = awaited_q.pop_front();
          if (out_data.read_value !== exp_item.read_value)
            report("read_value", out_data.read_value, exp_item.read_value);
          if (out_data.run_done !== exp_item.run_done)
            report("run_done", tpbb_pkg::PixW'(out_data.run_done),
                   tpbb_pkg::PixW'(exp_item.run_done));
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.cmd)
          tpbb_pkg::CMD_WRITE: image_mem[in_data.pixel_address] = in_data.pixel_value;
          tpbb_pkg::CMD_RUN: begin
            blur_image();
            exp_item.read_value = '0;
            exp_item.run_done = 1'b1;
            awaited_q.push_back(exp_item);
          end
          tpbb_pkg::CMD_READ: begin
            exp_item.read_value = image_mem[in_data.pixel_address];
            exp_item.run_done = 1'b0;
            awaited_q.push_back(exp_item);
          end
          default: ;
        endcase
      end
      pending = awaited_q.size();
    end
  end
endmodule

### test/three_pass_box_blur_tb.sv
// Testbench top that drives the blur block and prints the verdict.
`timescale 1ns / 1ps
module three_pass_box_blur_tb;
  localparam int CycleLimit = 10000000;
  localparam logic [tpbb_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [tpbb_pkg::CmdW-1:0] CmdUnused = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tpbb_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [tpbb_pkg::CfgDataW-1:0] cfg_data = '0;
  int pending;
  int fail_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int cur_w, cur_h;
  logic [tpbb_pkg::AddrW-1:0] extra_addrs [$];

  tpbb_if #(.payload_t(tpbb_pkg::in_item_t)) in_ch ();
  tpbb_if #(.payload_t(tpbb_pkg::out_item_t)) out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  three_pass_box_blur DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  three_pass_box_blur_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls at random and, on request, holds off for a long stretch.
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send(input logic [tpbb_pkg::CmdW-1:0] cmd,
                      input logic [tpbb_pkg::AddrW-1:0] addr,
                      input logic [tpbb_pkg::PixW-1:0] val);
    tpbb_pkg::in_item_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item.cmd = cmd;
    item.pixel_address = addr;
    item.pixel_value = val;
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic configure(input int w, input int h, input int r);
    cfg_we <= 1'b1;
    cfg_index <= tpbb_pkg::CFG_WIDTH;
    cfg_data <= tpbb_pkg::CfgDataW'(w);
    @(posedge clk);
    cfg_index <= tpbb_pkg::CFG_HEIGHT;
    cfg_data <= tpbb_pkg::CfgDataW'(h);
    @(posedge clk);
    cfg_index <= tpbb_pkg::CFG_RADIUS;
    cfg_data <= tpbb_pkg::CfgDataW'(r);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_w = (w == 0) ? 1 : (w > tpbb_pkg::MaxWidth) ? tpbb_pkg::MaxWidth : w;
    cur_h = (h == 0) ? 1 : (h > tpbb_pkg::MaxHeight) ? tpbb_pkg::MaxHeight : h;
  endtask

  task automatic fill_image();
    int a;
    for (a = 0; a < cur_w * cur_h; a++)
      send(tpbb_pkg::CMD_WRITE, tpbb_pkg::AddrW'(a), $urandom);
  endtask

  function automatic logic [tpbb_pkg::AddrW-1:0] pick_written();
    if (extra_addrs.size() > 0 && $urandom_range(3) == 0)
      return extra_addrs[$urandom_range(extra_addrs.size() - 1)];
    return tpbb_pkg::AddrW'($urandom_range(cur_w * cur_h - 1));
  endfunction

  task automatic random_items(input int count);
    int i, pick;
    logic [tpbb_pkg::AddrW-1:0] addr;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send(tpbb_pkg::CMD_WRITE, tpbb_pkg::AddrW'($urandom_range(cur_w * cur_h - 1)),
             $urandom);
      end else if (pick < 58) begin
        addr = tpbb_pkg::AddrW'($urandom);
        send(tpbb_pkg::CMD_WRITE, addr, $urandom);
        extra_addrs.push_back(addr);
      end else if (pick < 84) begin
        send(tpbb_pkg::CMD_READ, pick_written(), $urandom);
      end else if (pick < 93) begin
        send(tpbb_pkg::CMD_RUN, tpbb_pkg::AddrW'($urandom), $urandom);
      end else begin
        send(CmdUnused, tpbb_pkg::AddrW'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    int phase, set, i, r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_we <= 1'b1;
    cfg_index <= CfgUnused;
    cfg_data <= 9'h1FF;
    @(posedge clk);
    cfg_we <= 1'b0;
    configure(4, 3, 1);
    send(tpbb_pkg::CMD_WRITE, 16'd0, 32'h0000_0000);
    send(tpbb_pkg::CMD_WRITE, 16'd1, 32'hFFFF_FFFF);
    for (i = 2; i < 12; i++) send(tpbb_pkg::CMD_WRITE, tpbb_pkg::AddrW'(i), $urandom);
    send(tpbb_pkg::CMD_WRITE, 16'hFFFF, 32'hA5A5_5A5A);
    send(tpbb_pkg::CMD_READ, 16'hFFFF, 32'h0);
    send(CmdUnused, 16'hFFFF, 32'hFFFF_FFFF);
    send(tpbb_pkg::CMD_RUN, 16'h0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd11, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'hFFFF, 32'h0);
    wait_idle();
    configure(4, 3, 0);
    send(tpbb_pkg::CMD_RUN, 16'h0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd5, 32'h0);
    wait_idle();
    configure(2, 2, 63);
    send(tpbb_pkg::CMD_RUN, 16'h0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd3, 32'h0);
    wait_idle();
    configure(0, 0, 5);
    send(tpbb_pkg::CMD_RUN, 16'h0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd0, 32'h0);
    wait_idle();
    configure(511, 1, 63);
    fill_image();
    send(tpbb_pkg::CMD_RUN, 16'h0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd255, 32'h0);
    wait_idle();
    configure(0, 511, 1);
    fill_image();
    send(tpbb_pkg::CMD_RUN, 16'h0, 32'h0);
    send(tpbb_pkg::CMD_READ, 16'd128, 32'h0);
    wait_idle();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 10 : 0;
      for (set = 0; set < 3; set++) begin
        r = ($urandom_range(7) == 0) ? $urandom_range(32, 63) : $urandom_range(0, 5);
        configure($urandom_range(1, 6), $urandom_range(1, 6), r);
        fill_image();
        random_items(12);
        wait_idle();
      end
    end

    hold_request = hold_request + 1;
    for (i = 0; i < 40; i++) send(tpbb_pkg::CMD_READ, pick_written(), $urandom);
    wait_idle();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
